// ===== rtl/bwtm_pkg.sv =====
// Shared types and constants for the binary window template matcher.
// No dependencies; every other file in rtl/ imports this package.
package bwtm_pkg;

  localparam int SIDE   = 8;
  localparam int WIN_W  = SIDE * SIDE;
  localparam int COORD_W = 10;
  localparam int GRID_W = 11;
  localparam int SHAPE_W = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_TEMPLATE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHAPE_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHAPE_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT  = 3'd4;

  typedef struct packed {
    logic [WIN_W-1:0]   expect_bits;
    logic [WIN_W-1:0]   care_mask;
    logic [SHAPE_W-1:0] w;
    logic [SHAPE_W-1:0] h;
    logic [SHAPE_W-1:0] off_x;
    logic [SHAPE_W-1:0] off_y;
    logic [GRID_W-1:0]  gw;
    logic [GRID_W-1:0]  gh;
  } cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } hit_t;

endpackage

// ===== rtl/bwtm_cfg.sv =====
// Configuration registers and derived match pattern for the template matcher.
// Depends on bwtm_pkg.
module bwtm_cfg #(
  parameter int MAX_GRID_WIDTH = 1024,
  parameter int MAX_SHAPE_SIDE = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bwtm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bwtm_pkg::CFG_DATA_W-1:0]    cfg_data,
  output bwtm_pkg::cfg_t                     cfg
);
  import bwtm_pkg::*;

  localparam int GWMAX = (MAX_GRID_WIDTH < 1024) ? MAX_GRID_WIDTH : 1024;

  logic [WIN_W-1:0]   template_bits;
  logic [SHAPE_W-1:0] shape_width;
  logic [SHAPE_W-1:0] shape_height;
  logic [GRID_W-1:0]  grid_width;
  logic [GRID_W-1:0]  grid_height;

  logic [WIN_W-1:0]   expect_bits, expect_bits_next;
  logic [WIN_W-1:0]   care_mask, care_mask_next;
  logic [SHAPE_W-1:0] w, w_next, h, h_next;
  logic [SHAPE_W-1:0] off_x, off_y;
  logic [SHAPE_W-1:0] rr, cc;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      template_bits <= '0;
      shape_width   <= SHAPE_W'(1);
      shape_height  <= SHAPE_W'(1);
      grid_width    <= GRID_W'(1024);
      grid_height   <= GRID_W'(1024);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TEMPLATE:     template_bits <= cfg_data;
        REG_SHAPE_WIDTH:  shape_width   <= cfg_data[SHAPE_W-1:0];
        REG_SHAPE_HEIGHT: shape_height  <= cfg_data[SHAPE_W-1:0];
        REG_GRID_WIDTH:   grid_width    <= cfg_data[GRID_W-1:0];
        REG_GRID_HEIGHT:  grid_height   <= cfg_data[GRID_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (shape_width == '0)
      w_next = SHAPE_W'(1);
    else if (shape_width > SHAPE_W'(MAX_SHAPE_SIDE))
      w_next = SHAPE_W'(MAX_SHAPE_SIDE);
    else
      w_next = shape_width;
    if (shape_height == '0)
      h_next = SHAPE_W'(1);
    else if (shape_height > SHAPE_W'(MAX_SHAPE_SIDE))
      h_next = SHAPE_W'(MAX_SHAPE_SIDE);
    else
      h_next = shape_height;
  end

  // window bit j*8+k holds the cell j columns and k rows back from the corner
  always_comb begin
    expect_bits_next = '0;
    care_mask_next   = '0;
    rr = '0;
    cc = '0;
    for (int j = 0; j < SIDE; j++) begin
      for (int k = 0; k < SIDE; k++) begin
        rr = h_next - SHAPE_W'(1) - SHAPE_W'(k);
        cc = w_next - SHAPE_W'(1) - SHAPE_W'(j);
        if (SHAPE_W'(j) < w_next && SHAPE_W'(k) < h_next) begin
          care_mask_next[j*SIDE+k]   = 1'b1;
          expect_bits_next[j*SIDE+k] = template_bits[{rr[2:0], cc[2:0]}];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expect_bits <= '0;
      care_mask   <= WIN_W'(1);
      w           <= SHAPE_W'(1);
      h           <= SHAPE_W'(1);
      off_x       <= '0;
      off_y       <= '0;
    end else begin
      expect_bits <= expect_bits_next;
      care_mask   <= care_mask_next;
      w           <= w_next;
      h           <= h_next;
      off_x       <= w_next - SHAPE_W'(1) - (w_next >> 1);
      off_y       <= h_next - SHAPE_W'(1) - (h_next >> 1);
    end
  end

  always_comb begin
    cfg.expect_bits = expect_bits;
    cfg.care_mask   = care_mask;
    cfg.w           = w;
    cfg.h           = h;
    cfg.off_x       = off_x;
    cfg.off_y       = off_y;
    if (grid_width == '0)
      cfg.gw = GRID_W'(1);
    else if (grid_width > GRID_W'(GWMAX))
      cfg.gw = GRID_W'(GWMAX);
    else
      cfg.gw = grid_width;
    if (grid_height == '0)
      cfg.gh = GRID_W'(1);
    else if (grid_height > GRID_W'(1024))
      cfg.gh = GRID_W'(1024);
    else
      cfg.gh = grid_height;
  end

endmodule

// ===== rtl/bwtm_front.sv =====
// Front end: accepts cells, tracks position, line store and window, flags matches.
// Depends on bwtm_pkg.
module bwtm_front #(
  parameter int MAX_GRID_WIDTH = 1024,
  parameter int IDXW = $clog2(MAX_GRID_WIDTH)
) (
  input  logic           clk,
  input  logic           rst,
  input  bwtm_pkg::cfg_t cfg,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           in_cell,
  output logic           push,
  output bwtm_pkg::hit_t push_data,
  input  logic           full
);
  import bwtm_pkg::*;

  logic [SIDE-2:0] row_store [MAX_GRID_WIDTH];

  logic [COORD_W-1:0] x, y;
  logic [IDXW-1:0]    idx;
  logic               acc, x_end, y_end;

  logic               s1_valid, s1_adv;
  logic               s1_cell;
  logic [COORD_W-1:0] s1_x, s1_y;
  logic [IDXW-1:0]    s1_idx;
  logic [SIDE-2:0]    rd;

  logic               last_wr;
  logic [IDXW-1:0]    last_idx;
  logic [SIDE-2:0]    last_col;

  logic [WIN_W-1:0]   window, window_next;
  logic [SIDE-2:0]    above;
  logic [SIDE-1:0]    column;
  logic               fits, match;

  assign acc      = in_valid && in_ready;
  assign s1_adv   = s1_valid && !full;
  assign in_ready = !s1_valid || s1_adv;

  assign x_end = ({1'b0, x} + GRID_W'(1)) >= cfg.gw;
  assign y_end = ({1'b0, y} + GRID_W'(1)) >= cfg.gh;

  always_ff @(posedge clk) begin
    if (rst) begin
      x        <= '0;
      y        <= '0;
      idx      <= '0;
      s1_valid <= 1'b0;
      last_wr  <= 1'b0;
      window   <= '0;
    end else begin
      if (acc) begin
        s1_valid <= 1'b1;
        if (x_end) begin
          x   <= '0;
          idx <= '0;
          y   <= y_end ? '0 : y + COORD_W'(1);
        end else begin
          x   <= x + COORD_W'(1);
          idx <= (idx == IDXW'(MAX_GRID_WIDTH - 1)) ? '0 : idx + IDXW'(1);
        end
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        last_wr <= 1'b1;
        window  <= window_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      rd      <= row_store[idx];
      s1_cell <= in_cell;
      s1_x    <= x;
      s1_y    <= y;
      s1_idx  <= idx;
    end
    if (s1_adv) begin
      row_store[s1_idx] <= column[SIDE-2:0];
      last_idx          <= s1_idx;
      last_col          <= column[SIDE-2:0];
    end
  end

  // the previous word may write this column on the edge that read it
  assign above       = (last_wr && last_idx == s1_idx) ? last_col : rd;
  assign column      = {above, s1_cell};
  assign window_next = {window[WIN_W-SIDE-1:0], column};

  assign fits  = ({1'b0, s1_x} + GRID_W'(1)) >= GRID_W'(cfg.w) &&
                 ({1'b0, s1_y} + GRID_W'(1)) >= GRID_W'(cfg.h);
  assign match = ((window_next ^ cfg.expect_bits) & cfg.care_mask) == '0;

  assign push        = s1_adv && fits && match;
  assign push_data.x = s1_x;
  assign push_data.y = s1_y;

endmodule

// ===== rtl/bwtm_fifo.sv =====
// Short queue of match corners between front and back ends.
// Depends on bwtm_pkg.
module bwtm_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  bwtm_pkg::hit_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output bwtm_pkg::hit_t pop_data
);
  import bwtm_pkg::*;

  hit_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push, do_pop;

  assign full      = count == (QPTR_W+1)'(QDEPTH);
  assign not_empty = count != '0;
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (do_pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      case ({do_push, do_pop})
        2'b10:   count <= count + (QPTR_W+1)'(1);
        2'b01:   count <= count - (QPTR_W+1)'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_data;
  end

endmodule

// ===== rtl/bwtm_back.sv =====
// Back end: turns a match corner into the window center and holds the output word.
// Depends on bwtm_pkg.
module bwtm_back (
  input  logic                           clk,
  input  logic                           rst,
  input  bwtm_pkg::cfg_t                 cfg,
  input  logic                           in_valid,
  input  bwtm_pkg::hit_t                 in_data,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [bwtm_pkg::COORD_W-1:0]   center_x,
  output logic [bwtm_pkg::COORD_W-1:0]   center_y
);
  import bwtm_pkg::*;

  logic load;

  assign load = in_valid && (!out_valid || out_ready);
  assign pop  = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      center_x <= in_data.x - COORD_W'(cfg.off_x);
      center_y <= in_data.y - COORD_W'(cfg.off_y);
    end
  end

endmodule

// ===== rtl/binary_window_template_match_unit.sv =====
// Top level of the binary window template matcher.
// Depends on bwtm_pkg, bwtm_cfg, bwtm_front, bwtm_fifo, bwtm_back.
//
//   channel   direction  word                      fires when
//   s_axis    in         tdata[0] cell_req         s_axis_tvalid & s_axis_tready
//   m_axis    out        tdata[9:0] center_x,      m_axis_tvalid & m_axis_tready
//                        tdata[19:10] center_y
//   cfg       in         cfg_index, cfg_data       cfg_valid & cfg_ready
//
// One cell per cycle unless the queue is full; matches go through the queue to m_axis.
// The line store is one read and one write per cycle; a one-deep bypass covers same-column
// reuse. Reset (rst, synchronous) clears counters, window, queue and output valid.
// Output stalls fill a four-word queue, after which s_axis_tready drops.
// cfg_ready is always high; writes update the config registers, then the match pattern.
module binary_window_template_match_unit #(
  parameter int MAX_GRID_WIDTH = 1024,
  parameter int MAX_SHAPE_SIDE = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // [0] cell_req
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [23:0]                     m_axis_tdata,  // [9:0] center_x, [19:10] center_y
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bwtm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bwtm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bwtm_pkg::*;

  cfg_t               cfg;
  logic               push, full, pop, not_empty;
  hit_t               push_data, pop_data;
  logic [COORD_W-1:0] center_x, center_y;

  bwtm_cfg #(
    .MAX_GRID_WIDTH(MAX_GRID_WIDTH),
    .MAX_SHAPE_SIDE(MAX_SHAPE_SIDE)
  ) u_cfg (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .cfg(cfg)
  );

  bwtm_front #(
    .MAX_GRID_WIDTH(MAX_GRID_WIDTH)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .in_cell(s_axis_tdata[0]),
    .push(push),
    .push_data(push_data),
    .full(full)
  );

  bwtm_fifo u_fifo (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_data(push_data),
    .full(full),
    .pop(pop),
    .not_empty(not_empty),
    .pop_data(pop_data)
  );

  bwtm_back u_back (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .in_valid(not_empty),
    .in_data(pop_data),
    .pop(pop),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .center_x(center_x),
    .center_y(center_y)
  );

  assign m_axis_tdata = {4'b0, center_y, center_x};

endmodule
